// File: rtl/ist_pkg.sv
// Shared types and codes for the integer set table.
`default_nettype none

package ist_pkg;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HELD    = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_REPLY
  } state_t;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/ist_front.sv
// Request front end: decodes the operation and buffers items in a two-entry queue.
`default_nettype none

module ist_front
  import ist_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output      logic               req_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] element,
  output      logic               q_valid,
  output      item_t              q_item,
  input  wire logic               q_take
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  item_t      decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.value = element;
    unique case (func)
      FUNC_INSERT: decoded.op = OP_INSERT;
      FUNC_REMOVE: decoded.op = OP_REMOVE;
      default:     decoded.op = OP_QUERY;
    endcase
  end

  assign req_stall = (used == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (used != 2'd0);
  assign pop       = q_take && q_valid;
  assign q_item    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decoded;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ist_back.sv
// Table engine: linear search, append, compacting remove and the result register.
`default_nettype none

module ist_back
  import ist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output      logic       q_take,
  output      logic       rsp_valid,
  input  wire logic       rsp_stall,
  output      logic [1:0] status,
  output      logic       present,
  output      logic [4:0] count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > 5) ? FW : 5;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  state_t        state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [FW-1:0] fill, fill_next;
  item_t         cur, cur_next;
  logic          res_present, present_next;
  status_t       res_status, status_next;
  logic          rsp_load;

  logic [FW:0]   fill_x;
  logic [FW:0]   idx_p1;
  logic [FW:0]   idx_p2;
  logic [CW-1:0] fill_wide;

  assign fill_x    = {1'b0, fill};
  assign idx_p1    = (FW + 1)'(idx) + (FW + 1)'(1);
  assign idx_p2    = (FW + 1)'(idx) + (FW + 1)'(2);
  assign fill_wide = CW'(fill);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    fill_next    = fill;
    cur_next     = cur;
    present_next = res_present;
    status_next  = res_status;
    q_take       = 1'b0;
    rd_addr      = idx;
    wr_en        = 1'b0;
    wr_addr      = idx;
    wr_data      = rd_data;
    rsp_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_take       = 1'b1;
          cur_next     = q_item;
          idx_next     = '0;
          rd_addr      = '0;
          present_next = 1'b0;
          if (fill == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (rd_data == cur.value) begin
          present_next = 1'b1;
          state_next   = S_DECIDE;
        end else if (idx_p1 < fill_x) begin
          idx_next = idx_p1[IW-1:0];
          rd_addr  = idx_p1[IW-1:0];
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_REPLY;
        unique case (cur.op)
          OP_INSERT: begin
            if (res_present) begin
              status_next = ST_HELD;
            end else if (fill_x >= (FW + 1)'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = fill[IW-1:0];
              wr_data     = cur.value;
              fill_next   = fill + FW'(1);
              status_next = ST_OK;
            end
          end
          OP_REMOVE: begin
            if (!res_present) begin
              status_next = ST_MISSING;
            end else if (idx_p1 < fill_x) begin
              rd_addr    = idx_p1[IW-1:0];
              state_next = S_SHIFT;
            end else begin
              fill_next   = fill - FW'(1);
              status_next = ST_OK;
            end
          end
          default: begin
            status_next = res_present ? ST_OK : ST_MISSING;
          end
        endcase
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (idx_p2 < fill_x) begin
          rd_addr  = idx_p2[IW-1:0];
          idx_next = idx_p1[IW-1:0];
        end else begin
          fill_next   = fill - FW'(1);
          status_next = ST_OK;
          state_next  = S_REPLY;
        end
      end
      S_REPLY: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    cur         <= cur_next;
    res_present <= present_next;
    res_status  <= status_next;
    if (rsp_load) begin
      status  <= res_status;
      present <= res_present;
      count   <= fill_wide[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_x <= (FW + 1)'(CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  a_search_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (FW + 1)'(idx) < fill_x)
    else $error("Search reads beyond the held entries.");

  a_shift_only_remove: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> cur.op == OP_REMOVE && res_present)
    else $error("Table shift without a matching remove.");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE && cur.op == OP_INSERT && fill_x == (FW + 1)'(CAPACITY)
    |=> fill == $past(fill))
    else $error("Insert into a full table changed the entry count.");
`endif

endmodule

`default_nettype wire

// File: rtl/integer_set_table.sv
// Integer set table: top level joining the request front end and the table engine.
// A result is offered once its item has left the queue and gone through a walk for search plus
// shift, a decision and a reply; the single-port engine takes no new item until that result is loaded.
// Reset: synchronous rst empties the set, the request queue and the result register.
`default_nettype none

module integer_set_table
  import ist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output      logic               req_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] element,
  output      logic               rsp_valid,
  input  wire logic               rsp_stall,
  output      logic [1:0]         status,
  output      logic               present,
  output      logic [4:0]         count
);

  logic  q_valid;
  item_t q_item;
  logic  q_take;

  ist_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .element   (element),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  ist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .present   (present),
    .count     (count)
  );

endmodule

`default_nettype wire

// File: dv/tb_integer_set_table.sv
// Self-checking testbench for the integer set table: predicted results against the block.
`timescale 1ns / 1ps

module tb_integer_set_table;
  import ist_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_ITEMS = 100;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int POOL_SIZE = 20;
  localparam logic [1:0] FUNC_QUERY = OP_QUERY;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] value;
    int                 gap;
    bit                 idle_ok;
    bit                 drain;
    bit                 hold;
  } request_t;

  typedef struct {
    status_t    status;
    logic       present;
    logic [4:0] count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         func = '0;
  logic signed [31:0] element = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic               present;
  logic [4:0]         count;

  request_t           pending[$];
  outcome_t           expected[$];
  logic signed [31:0] set_vals[TABLE_DEPTH];
  int                 set_fill = 0;
  int                 peak_fill = 0;
  int                 errors = 0;
  int                 n_sent = 0;
  int                 n_checked = 0;
  int                 status_seen[4] = '{0, 0, 0, 0};
  int                 hold_requests = 0;
  bit                 rx_idle_ok = 1'b1;
  int                 quiet_cycles = 0;

  integer_set_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func(func),
    .element(element),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .present(present),
    .count(count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_set_op(input logic [1:0] op, input logic signed [31:0] value);
    int pos;
    bit held;
    outcome_t res;
    pos = set_fill;
    for (int i = set_fill - 1; i >= 0; i--) begin
      if (set_vals[i] == value) pos = i;
    end
    held = pos < set_fill;
    case (op)
      FUNC_INSERT: begin
        if (held) begin
          res.status = ST_HELD;
        end else if (set_fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          set_vals[set_fill] = value;
          set_fill++;
          res.status = ST_OK;
        end
      end
      FUNC_REMOVE: begin
        if (!held) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = pos; i + 1 < set_fill; i++) set_vals[i] = set_vals[i + 1];
          set_fill--;
          res.status = ST_OK;
        end
      end
      default: begin
        res.status = held ? ST_OK : ST_MISSING;
      end
    endcase
    res.present = held;
    res.count = 5'(set_fill);
    if (set_fill > peak_fill) peak_fill = set_fill;
    expected.push_back(res);
  endtask

  task automatic queue_request(input logic [1:0] op, input logic signed [31:0] value,
                               input int gap, input bit idle_ok, input bit drain,
                               input bit hold);
    request_t r;
    r.op = op;
    r.value = value;
    r.gap = gap;
    r.idle_ok = idle_ok;
    r.drain = drain;
    r.hold = hold;
    pending.push_back(r);
  endtask

  always @(posedge clk) begin : drive_requests
    request_t next_req;
    int gap_left;
    if (rst) begin
      req_valid <= 1'b0;
      func <= '0;
      element <= '0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_set_op(func, element);
        n_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending.size() != 0 && pending[0].gap != 0) begin
          gap_left = pending[0].gap - 1;
          pending[0].gap = 0;
          req_valid <= 1'b0;
        end else if (pending.size() != 0 && (!pending[0].drain || expected.size() == 0)) begin
          next_req = pending.pop_front();
          func <= next_req.op;
          element <= next_req.value;
          req_valid <= 1'b1;
          rx_idle_ok <= next_req.idle_ok;
          if (next_req.hold) hold_requests <= hold_requests + 1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    int stall_left;
    int hold_left;
    int holds_served;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      holds_served = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_checked++;
        status_seen[status]++;
        if (expected.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d present %0d count %0d",
                   $time, status, present, count);
          errors++;
        end else begin
          want = expected.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (present !== want.present) begin
            $display("%0t: present expected %0d actual %0d", $time, want.present, present);
            errors++;
          end
          if (count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, count);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (rx_idle_ok && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        !(pending.size() != 0 || req_valid || expected.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles with %0d results outstanding",
               $time, quiet_cycles, expected.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [31:0] pool[POOL_SIZE];
    bit insert_heavy;
    bit idle_seg;
    bit calm;
    int quiet_left;
    int pick;
    logic [1:0] op;
    logic signed [31:0] value;
    int gap;

    queue_request(FUNC_QUERY, 32'sh8000_0000, 0, 1, 0, 0);
    queue_request(FUNC_REMOVE, 32'sh0, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh8000_0000, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, -32'sd1, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh0, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh1, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh5555_5555, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'shAAAA_AAAA, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh8000_0000, 0, 1, 0, 0);
    queue_request(FUNC_SPARE, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    queue_request(FUNC_REMOVE, -32'sd1, 0, 1, 0, 0);
    queue_request(FUNC_REMOVE, 32'sh8000_0000, 0, 1, 0, 0);
    queue_request(FUNC_QUERY, -32'sd1, 0, 1, 0, 0);
    for (int k = 0; k < 11; k++) queue_request(FUNC_INSERT, 32'sh1000_0000 + k, 0, 1, 0, 0);
    queue_request(FUNC_INSERT, 32'sh1234_5678, 0, 1, 1, 0);
    queue_request(FUNC_INSERT, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    queue_request(FUNC_REMOVE, 32'sh1000_000A, 0, 1, 0, 0);

    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sh0;
    pool[3] = -32'sd1;
    for (int k = 4; k < POOL_SIZE; k++) pool[k] = $urandom;
    insert_heavy = 1'b1;
    idle_seg = 1'b1;
    quiet_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        insert_heavy = (n / 50) % 2 == 0;
        idle_seg = $urandom_range(0, 3) != 0;
        for (int k = 0; k < 6; k++) pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      end
      calm = n >= RANDOM_ITEMS - CALM_ITEMS;
      pick = $urandom_range(0, 99);
      if (insert_heavy) begin
        op = pick < 60 ? FUNC_INSERT : pick < 80 ? FUNC_REMOVE : pick < 95 ? FUNC_QUERY
                                                                            : FUNC_SPARE;
      end else begin
        op = pick < 25 ? FUNC_INSERT : pick < 80 ? FUNC_REMOVE : pick < 95 ? FUNC_QUERY
                                                                            : FUNC_SPARE;
      end
      value = $urandom_range(0, 9) < 7 ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom;
      if (n == 120 || n == 420) quiet_left = 40;
      gap = 0;
      if (!calm && idle_seg && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
      end
      queue_request(op, value, gap, !calm && idle_seg, n == 300 || n == 550,
                    n == 120 || n == 420);
      if (quiet_left > 0) quiet_left--;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid) @(posedge clk);
    while (expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d requests: %0d success, %0d already held, %0d absent, %0d full.",
             n_checked, n_sent, status_seen[ST_OK], status_seen[ST_HELD],
             status_seen[ST_MISSING], status_seen[ST_FULL]);
    $display("The set peaked at %0d of %0d entries, with output hold-offs and pipeline drains.",
             peak_fill, TABLE_DEPTH);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
